[src/btb_pkg.sv]
// Shared types, constants and helpers for the branch target buffer.
package btb_pkg;

    localparam int ENTRIES       = 32;
    localparam int IDX_W         = $clog2(ENTRIES);
    localparam int HIST_W        = 8;
    localparam int CTR_PER_ENTRY = 1 << HIST_W;
    localparam int PRIV_DEPTH    = ENTRIES * CTR_PER_ENTRY;
    localparam int PRIV_AW       = $clog2(PRIV_DEPTH);
    localparam int TAG_W         = 30;
    localparam int CTR_W         = 2;
    localparam int ADDR_W        = 5;

    localparam logic [2:0] REG_ENTRIES_LOG2 = 3'd0;
    localparam logic [2:0] REG_HISTORY_BITS = 3'd1;
    localparam logic [2:0] REG_TAG_BITS     = 3'd2;
    localparam logic [2:0] REG_INIT_CTR     = 3'd3;
    localparam logic [2:0] REG_GLOBAL_HIST  = 3'd4;
    localparam logic [2:0] REG_SHARED_TABLE = 3'd5;
    localparam logic [2:0] REG_SHARE_MODE   = 3'd6;

    localparam logic [1:0] SHARE_PC_LOW  = 2'd1;
    localparam logic [1:0] SHARE_PC_HIGH = 2'd2;

    typedef struct packed {
        logic [2:0]        lb;
        logic [HIST_W-1:0] hm;
        logic [4:0]        tb;
        logic [CTR_W-1:0]  init;
        logic              gmode;
        logic              smode;
        logic [1:0]        share;
    } cfg_t;

    typedef struct packed {
        logic               accept;
        logic               exec;
        logic               fill;
        logic               sweep;
        logic [PRIV_AW-1:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic need_fill;
        logic fill_last;
    } sts_t;

    function automatic logic [CTR_W-1:0] train(input logic [CTR_W-1:0] c, input logic tk);
        logic [CTR_W-1:0] r;
        r = c;
        if (tk)
        begin
            if (c != 2'd3)
                r = c + 2'd1;
        end
        else
        begin
            if (c != 2'd0)
                r = c - 2'd1;
        end
        return r;
    endfunction

endpackage

[src/btb_two_level_branch_predictor_unit.sv]
// Top level of the two-level branch predictor with target buffer.
//
//  Channel   Handshake                     Payload
//  item in   start, busy                   action, pc, resolved_target,
//                                          resolved_taken, earlier_prediction
//  result    done (one-cycle strobe)       predicted_taken, next_pc, mispredict,
//                                          branch_count, flush_count
//  config    psel, penable, pwrite, pready paddr, pwdata, prdata
//
// An item passes through a counter RAM read, then the execute state; done
// follows in the next cycle while a new item may already be taken.
// An update that allocates with private counters adds a refill of that entry's counters.
// After reset and after a write of initial_counter while idle, busy stays high
// while the counter tables are swept. The receiver cannot stall results.
module btb_two_level_branch_predictor_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       action,
    input  logic [31:0]                pc,
    input  logic [31:0]                resolved_target,
    input  logic                       resolved_taken,
    input  logic [31:0]                earlier_prediction,
    output logic                       done,
    output logic                       predicted_taken,
    output logic [31:0]                next_pc,
    output logic                       mispredict,
    output logic [31:0]                branch_count,
    output logic [31:0]                flush_count,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [btb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    btb_pkg::cfg_t cfg;
    btb_pkg::cmd_t cmd;
    btb_pkg::sts_t sts;
    logic          init_wr;

    btb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .init_wr (init_wr)
    );

    btb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .init_wr (init_wr),
        .sts     (sts),
        .cmd     (cmd),
        .busy    (busy)
    );

    btb_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .cmd                (cmd),
        .sts                (sts),
        .action             (action),
        .pc                 (pc),
        .resolved_target    (resolved_target),
        .resolved_taken     (resolved_taken),
        .earlier_prediction (earlier_prediction),
        .done               (done),
        .predicted_taken    (predicted_taken),
        .next_pc            (next_pc),
        .mispredict         (mispredict),
        .branch_count       (branch_count),
        .flush_count        (flush_count)
    );

endmodule

[src/btb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module btb_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/btb_cfg.sv]
// Configuration registers behind the APB-style port.
module btb_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [btb_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output btb_pkg::cfg_t             cfg,
    output logic                      init_wr
);

    logic [2:0] entries_log2_reg;
    logic [3:0] history_bits_reg;
    logic [4:0] tag_bits_reg;
    logic [1:0] init_ctr_reg;
    logic       global_hist_reg;
    logic       shared_table_reg;
    logic [1:0] share_mode_reg;
    logic       wr;
    logic [2:0] idx;
    logic [3:0] hb;

    assign pready  = 1'b1;
    assign wr      = psel & penable & pwrite;
    assign idx     = paddr[4:2];
    assign init_wr = wr && (idx == btb_pkg::REG_INIT_CTR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_log2_reg <= 3'd5;
            history_bits_reg <= 4'd8;
            tag_bits_reg     <= 5'd25;
            init_ctr_reg     <= 2'd1;
            global_hist_reg  <= 1'b0;
            shared_table_reg <= 1'b0;
            share_mode_reg   <= 2'd0;
        end
        else if (wr)
        begin
            unique case (idx)
                btb_pkg::REG_ENTRIES_LOG2: entries_log2_reg <= pwdata[2:0];
                btb_pkg::REG_HISTORY_BITS: history_bits_reg <= pwdata[3:0];
                btb_pkg::REG_TAG_BITS:     tag_bits_reg     <= pwdata[4:0];
                btb_pkg::REG_INIT_CTR:     init_ctr_reg     <= pwdata[1:0];
                btb_pkg::REG_GLOBAL_HIST:  global_hist_reg  <= pwdata[0];
                btb_pkg::REG_SHARED_TABLE: shared_table_reg <= pwdata[0];
                btb_pkg::REG_SHARE_MODE:   share_mode_reg   <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            btb_pkg::REG_ENTRIES_LOG2: prdata = {29'd0, entries_log2_reg};
            btb_pkg::REG_HISTORY_BITS: prdata = {28'd0, history_bits_reg};
            btb_pkg::REG_TAG_BITS:     prdata = {27'd0, tag_bits_reg};
            btb_pkg::REG_INIT_CTR:     prdata = {30'd0, init_ctr_reg};
            btb_pkg::REG_GLOBAL_HIST:  prdata = {31'd0, global_hist_reg};
            btb_pkg::REG_SHARED_TABLE: prdata = {31'd0, shared_table_reg};
            btb_pkg::REG_SHARE_MODE:   prdata = {30'd0, share_mode_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        if (history_bits_reg == 4'd0)
            hb = 4'd1;
        else if (history_bits_reg > 4'(btb_pkg::HIST_W))
            hb = 4'(btb_pkg::HIST_W);
        else
            hb = history_bits_reg;
        cfg.lb    = (entries_log2_reg > 3'd5) ? 3'd5 : entries_log2_reg;
        cfg.hm    = 8'((9'd1 << hb) - 9'd1);
        cfg.tb    = (tag_bits_reg > 5'd30) ? 5'd30 : tag_bits_reg;
        cfg.init  = init_ctr_reg;
        cfg.gmode = global_hist_reg;
        cfg.smode = shared_table_reg;
        cfg.share = (share_mode_reg == 2'd3) ? 2'd0 : share_mode_reg;
    end

endmodule

[src/btb_ctrl.sv]
// Controller: item sequencing, counter refill and clearing sweep.
module btb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          init_wr,
    input  btb_pkg::sts_t sts,
    output btb_pkg::cmd_t cmd,
    output logic          busy
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FILL, S_SWEEP} state_t;

    state_t                      state_reg;
    logic [btb_pkg::PRIV_AW-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (init_wr)
                        state_reg <= S_SWEEP;
                    else if (start)
                        state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    cnt_reg <= '0;
                    state_reg <= sts.need_fill ? S_FILL : S_IDLE;
                end
                S_FILL:
                begin
                    if (sts.fill_last)
                        state_reg <= S_IDLE;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_SWEEP:
                begin
                    if (cnt_reg == btb_pkg::PRIV_AW'(btb_pkg::PRIV_DEPTH - 1))
                        state_reg <= S_IDLE;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy       = (state_reg != S_IDLE) || init_wr;
    assign cmd.accept = start && !busy;
    assign cmd.exec   = (state_reg == S_EXEC);
    assign cmd.fill   = (state_reg == S_FILL);
    assign cmd.sweep  = (state_reg == S_SWEEP);
    assign cmd.cnt    = cnt_reg;

endmodule

[src/btb_dp.sv]
// Datapath: entry store, counter tables, histories, totals and result registers.
module btb_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  btb_pkg::cfg_t cfg,
    input  btb_pkg::cmd_t cmd,
    output btb_pkg::sts_t sts,
    input  logic          action,
    input  logic [31:0]   pc,
    input  logic [31:0]   resolved_target,
    input  logic          resolved_taken,
    input  logic [31:0]   earlier_prediction,
    output logic          done,
    output logic          predicted_taken,
    output logic [31:0]   next_pc,
    output logic          mispredict,
    output logic [31:0]   branch_count,
    output logic [31:0]   flush_count
);

    localparam int IW = btb_pkg::IDX_W;
    localparam int HW = btb_pkg::HIST_W;
    localparam int TW = btb_pkg::TAG_W;
    localparam int AW = btb_pkg::PRIV_AW;

    logic [btb_pkg::ENTRIES-1:0] valid_reg;
    logic [TW-1:0]  tag_reg    [btb_pkg::ENTRIES];
    logic [31:0]    target_reg [btb_pkg::ENTRIES];
    logic [HW-1:0]  hist_reg   [btb_pkg::ENTRIES];
    logic [HW-1:0]  ghist_reg;
    logic [31:0]    branch_reg, flush_reg;

    logic           action_reg, taken_reg, hit_reg;
    logic [31:0]    pc_reg, tgt_reg, pred_reg;
    logic [IW-1:0]  e_reg;
    logic [TW-1:0]  ptag_reg;
    logic [HW-1:0]  h_reg, sidx_reg, lhist_reg;

    logic           done_reg, pt_reg, misp_reg;
    logic [31:0]    npc_reg;

    logic [IW-1:0]  emask, e_in;
    logic [31:0]    shifted;
    logic [30:0]    tmask_w;
    logic [TW-1:0]  ptag_in;
    logic           hit_in;
    logic [HW-1:0]  ghist_m, lhist_in, h_in, sidx_in;

    logic [31:0]    pc4;
    logic [1:0]     pr_rdata, sh_rdata, ctr, trained, tinit;
    logic           flush, pred_t;
    logic [31:0]    branch_next, flush_next;

    logic           pr_we, sh_we;
    logic [AW-1:0]  pr_waddr;
    logic [HW-1:0]  sh_waddr;
    logic [1:0]     pr_wdata, sh_wdata;

    always_comb
    begin
        ghist_m  = ghist_reg & cfg.hm;
        emask    = IW'((6'd1 << cfg.lb) - 6'd1);
        e_in     = pc[2 +: IW] & emask;
        shifted  = pc >> (6'd2 + {3'd0, cfg.lb});
        tmask_w  = (31'd1 << cfg.tb) - 31'd1;
        ptag_in  = shifted[TW-1:0] & tmask_w[TW-1:0];
        hit_in   = valid_reg[e_in] && (tag_reg[e_in] == ptag_in);
        lhist_in = hist_reg[e_in] & cfg.hm;
        h_in     = cfg.gmode ? ghist_m : (hit_in ? lhist_in : '0);
        unique case (cfg.share)
            btb_pkg::SHARE_PC_LOW:  sidx_in = (h_in ^ pc[9:2]) & cfg.hm;
            btb_pkg::SHARE_PC_HIGH: sidx_in = (h_in ^ pc[23:16]) & cfg.hm;
            default:                sidx_in = h_in;
        endcase
    end

    always_comb
    begin
        pc4         = pc_reg + 32'd4;
        ctr         = cfg.smode ? sh_rdata : pr_rdata;
        trained     = btb_pkg::train(ctr, taken_reg);
        tinit       = btb_pkg::train(cfg.init, taken_reg);
        flush       = taken_reg ? (tgt_reg != pred_reg) : (pred_reg != pc4);
        pred_t      = hit_reg & ctr[1];
        branch_next = branch_reg + 32'd1;
        flush_next  = flush_reg + {31'd0, flush};
        sts.need_fill = action_reg & !hit_reg & !cfg.smode;
        sts.fill_last = (cmd.cnt[HW-1:0] == cfg.hm);
    end

    always_comb
    begin
        pr_we    = cmd.sweep | cmd.fill | (cmd.exec & action_reg & hit_reg & !cfg.smode);
        sh_we    = (cmd.sweep && (cmd.cnt[AW-1:HW] == '0)) | (cmd.exec & action_reg & cfg.smode);
        sh_waddr = cmd.sweep ? cmd.cnt[HW-1:0] : sidx_reg;
        sh_wdata = cmd.sweep ? cfg.init : trained;
        priority if (cmd.sweep)
        begin
            pr_waddr = cmd.cnt;
            pr_wdata = cfg.init;
        end
        else if (cmd.fill)
        begin
            pr_waddr = {e_reg, cmd.cnt[HW-1:0]};
            pr_wdata = (cmd.cnt[HW-1:0] == h_reg) ? tinit : cfg.init;
        end
        else
        begin
            pr_waddr = {e_reg, h_reg};
            pr_wdata = trained;
        end
    end

    btb_ram #(.WIDTH(btb_pkg::CTR_W), .DEPTH(btb_pkg::PRIV_DEPTH)) u_priv (
        .clk   (clk),
        .we    (pr_we),
        .waddr (pr_waddr),
        .wdata (pr_wdata),
        .raddr ({e_in, h_in}),
        .rdata (pr_rdata)
    );

    btb_ram #(.WIDTH(btb_pkg::CTR_W), .DEPTH(btb_pkg::CTR_PER_ENTRY)) u_shared (
        .clk   (clk),
        .we    (sh_we),
        .waddr (sh_waddr),
        .wdata (sh_wdata),
        .raddr (sidx_in),
        .rdata (sh_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            action_reg <= action;
            pc_reg     <= pc;
            tgt_reg    <= resolved_target;
            taken_reg  <= resolved_taken;
            pred_reg   <= earlier_prediction;
            e_reg      <= e_in;
            ptag_reg   <= ptag_in;
            hit_reg    <= hit_in;
            h_reg      <= h_in;
            sidx_reg   <= sidx_in;
            lhist_reg  <= lhist_in;
        end
        if (cmd.exec && action_reg)
        begin
            if (!hit_reg)
            begin
                tag_reg[e_reg]    <= ptag_reg;
                target_reg[e_reg] <= tgt_reg;
            end
            else if (taken_reg)
                target_reg[e_reg] <= tgt_reg;
        end
        if (cmd.exec)
        begin
            pt_reg   <= action_reg ? 1'b0 : pred_t;
            npc_reg  <= action_reg ? 32'd0 : (pred_t ? target_reg[e_reg] : pc4);
            misp_reg <= action_reg & flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            ghist_reg  <= '0;
            branch_reg <= '0;
            flush_reg  <= '0;
            done_reg   <= 1'b0;
            for (int i = 0; i < btb_pkg::ENTRIES; i++)
                hist_reg[i] <= '0;
        end
        else
        begin
            done_reg <= cmd.exec;
            if (cmd.exec && action_reg)
            begin
                valid_reg[e_reg] <= 1'b1;
                branch_reg       <= branch_next;
                flush_reg        <= flush_next;
                if (cfg.gmode)
                    ghist_reg <= ((ghist_m << 1) & cfg.hm) | {{(HW-1){1'b0}}, taken_reg};
                else if (hit_reg)
                    hist_reg[e_reg] <= ((lhist_reg << 1) & cfg.hm) | {{(HW-1){1'b0}}, taken_reg};
                else
                    hist_reg[e_reg] <= {{(HW-1){1'b0}}, taken_reg};
            end
        end
    end

    assign done            = done_reg;
    assign predicted_taken = pt_reg;
    assign next_pc         = npc_reg;
    assign mispredict      = misp_reg;
    assign branch_count    = branch_reg;
    assign flush_count     = flush_reg;

endmodule
